FILE: src/assert_macros.svh
// Assertion macros shared by the sliding window maximum RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: check failed");

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: src/swm_pkg.sv
// Shared constants and types for the sliding window maximum block.
// Depends on nothing; used by swm_cell and sliding_window_maximum.
package swm_pkg;

  localparam int DEF_MAX_WINDOW     = 64;
  localparam int DEF_MAX_ROW_LENGTH = 4096;
  localparam int DEF_SAMPLE_WIDTH   = 16;

  localparam int CFG_LEN_W  = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic                 REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_LEN_W-1:0] WINDOW_LENGTH_RST = 7'd1;

  typedef struct packed {
    logic clear;
    logic shift;
    logic append;
    logic full;
  } cell_ctl_t;

endpackage

FILE: src/swm_cell.sv
// One queue entry of the monotonic deque: value, row position and valid bit.
// Depends on swm_pkg; instanced in a row by sliding_window_maximum.
module swm_cell #(
  parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH,
  parameter int POS_W        = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  swm_pkg::cell_ctl_t       ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic [POS_W-1:0]         pos_new,
  input  logic                     left_keep,
  input  logic                     right_vld,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val,
  input  logic [POS_W-1:0]         right_pos,
  output logic                     vld,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic [POS_W-1:0]         pos,
  output logic                     keep
);
  import swm_pkg::*;

  logic                           vld_next;
  logic signed [SAMPLE_WIDTH-1:0] val_next;
  logic [POS_W-1:0]               pos_next;
  logic                           dom;

  assign dom  = vld && (val <= sample);
  assign keep = vld && !dom && !ctl.clear;

  always_comb begin
    vld_next = vld;
    val_next = val;
    pos_next = pos;
    if (ctl.shift) begin
      vld_next = right_vld;
      val_next = right_val;
      pos_next = right_pos;
    end else if (ctl.append) begin
      if (ctl.full) begin
        vld_next = right_vld;
        val_next = right_val;
        pos_next = right_pos;
      end else if (keep) begin
        vld_next = 1'b1;
      end else if (left_keep) begin
        vld_next = 1'b1;
        val_next = sample;
        pos_next = pos_new;
      end else begin
        vld_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    pos <= pos_next;
  end

endmodule

FILE: src/sliding_window_maximum.sv
// Sliding window maximum over a row of signed samples, kept as a chain of deque cells.
// Depends on swm_pkg, swm_cell and assert_macros.svh.
//
//  port group | dir | tdata (low bit up)              | tuser
//  s_*        | in  | sample_value                    | row_start
//  m_*        | out | max_value, max_position         | window_full
//  apb        | cfg | window_length at byte address 0 | -
//
// One transfer per cycle while no entry ages out of the window and the output is free.
// Aged-out entries hold s_tready low until dropped (one front drop per s_tvalid cycle).
// Result appears on m_* in the cycle after its transfer; while it waits, s_tready stays low.
// Synchronous reset empties the chain at once; entries carry valid bits, no clearing pass.
`include "assert_macros.svh"

module sliding_window_maximum #(
  parameter int MAX_WINDOW     = swm_pkg::DEF_MAX_WINDOW,
  parameter int MAX_ROW_LENGTH = swm_pkg::DEF_MAX_ROW_LENGTH,
  parameter int SAMPLE_WIDTH   = swm_pkg::DEF_SAMPLE_WIDTH,
  localparam int POS_W         = $clog2(MAX_ROW_LENGTH + 1),
  localparam int S_TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int M_TDATA_W     = ((SAMPLE_WIDTH + POS_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [S_TDATA_W-1:0]            s_tdata,  // sample_value
  input  logic                            s_tuser,  // row_start
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [M_TDATA_W-1:0]            m_tdata,  // max_value, max_position
  output logic                            m_tuser,  // window_full
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [swm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [swm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import swm_pkg::*;

  localparam int N       = MAX_WINDOW;
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = ((POS_W > WIN_W) ? POS_W : WIN_W) + 1;
  localparam int CLAMP_W = (CFG_LEN_W > WIN_W) ? CFG_LEN_W : WIN_W;

  logic [CFG_LEN_W-1:0]           window_length;
  logic [POS_W-1:0]               pos_ctr;
  logic [CLAMP_W-1:0]             len_ext;
  logic [WIN_W-1:0]               w_eff;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           row_start;
  logic [POS_W-1:0]               pos_new;
  logic                           front_exp;
  logic                           out_free;
  cell_ctl_t                      ctl;

  logic [N-1:0]                   cell_vld;
  logic [N-1:0]                   cell_keep;
  logic signed [SAMPLE_WIDTH-1:0] cell_val [N];
  logic [POS_W-1:0]               cell_pos [N];

  logic signed [SAMPLE_WIDTH-1:0] out_val;
  logic [POS_W-1:0]               out_pos;
  logic                           out_full;
  logic signed [SAMPLE_WIDTH-1:0] front_val;
  logic [POS_W-1:0]               front_pos;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? APB_DATA_W'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH)) begin
      window_length <= pwdata[CFG_LEN_W-1:0];
    end
  end

  assign len_ext = CLAMP_W'(window_length);

  always_comb begin
    if (len_ext == '0) begin
      w_eff = WIN_W'(1);
    end else if (len_ext > CLAMP_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = WIN_W'(len_ext);
    end
  end

  // input decode and row position
  assign sample    = $signed(s_tdata[SAMPLE_WIDTH-1:0]);
  assign row_start = s_tuser;

  always_comb begin
    if (row_start) begin
      pos_new = POS_W'(1);
    end else if (pos_ctr == POS_W'(MAX_ROW_LENGTH)) begin
      pos_new = pos_ctr;
    end else begin
      pos_new = pos_ctr + POS_W'(1);
    end
  end

  assign front_exp = !row_start && cell_vld[0] &&
                     (SUM_W'(cell_pos[0]) + SUM_W'(w_eff) <= SUM_W'(pos_new));
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !front_exp && out_free;

  assign ctl.clear  = row_start;
  assign ctl.shift  = s_tvalid && front_exp;
  assign ctl.append = s_tvalid && s_tready;
  assign ctl.full   = cell_keep[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_ctr <= '0;
    end else if (ctl.append) begin
      pos_ctr <= pos_new;
    end
  end

  // cell chain, front at index 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                           lk;
    logic                           rv;
    logic signed [SAMPLE_WIDTH-1:0] rval;
    logic [POS_W-1:0]               rpos;

    if (i == 0) begin : g_head
      assign lk = 1'b1;
    end else begin : g_body
      assign lk = cell_keep[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign rv   = ctl.append;
      assign rval = sample;
      assign rpos = pos_new;
    end else begin : g_mid
      assign rv   = cell_vld[i+1];
      assign rval = cell_val[i+1];
      assign rpos = cell_pos[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .POS_W        (POS_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sample    (sample),
      .pos_new   (pos_new),
      .left_keep (lk),
      .right_vld (rv),
      .right_val (rval),
      .right_pos (rpos),
      .vld       (cell_vld[i]),
      .val       (cell_val[i]),
      .pos       (cell_pos[i]),
      .keep      (cell_keep[i])
    );
  end

  // front of the updated queue
  always_comb begin
    if (ctl.full) begin
      front_val = cell_val[1];
      front_pos = cell_pos[1];
    end else if (cell_keep[0]) begin
      front_val = cell_val[0];
      front_pos = cell_pos[0];
    end else begin
      front_val = sample;
      front_pos = pos_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.append) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append) begin
      out_val  <= front_val;
      out_pos  <= front_pos;
      out_full <= (SUM_W'(pos_new) >= SUM_W'(w_eff));
    end
  end

  assign m_tdata = M_TDATA_W'({out_pos, out_val});
  assign m_tuser = out_full;

  `ASSERT_ALWAYS(a_vld_prefix, clk, rst, ((cell_vld >> 1) & ~cell_vld) == '0)
  `ASSERT_NEXT(a_front_filled, clk, rst, ctl.append, cell_vld[0] && m_tvalid)
  `ASSERT_ALWAYS(a_pos_sat, clk, rst, pos_ctr <= POS_W'(MAX_ROW_LENGTH))
  `ASSERT_IMPLIES(a_out_pos, clk, rst, m_tvalid, (out_pos <= pos_ctr) && (out_pos != '0))

endmodule

FILE: tb/tb_sliding_window_maximum.sv
// Self-checking bench for sliding_window_maximum: random samples and row starts
// on the input stream, windowed maxima checked against a deque model in a small class.
// Depends on swm_pkg and the sliding_window_maximum RTL.
`timescale 1ns / 100ps

module tb_sliding_window_maximum;

  localparam int          SAMPLE_W       = swm_pkg::DEF_SAMPLE_WIDTH;
  localparam int          POS_W          = 13;
  localparam int          MAX_WIN        = swm_pkg::DEF_MAX_WINDOW;
  localparam int          MAX_ROW        = swm_pkg::DEF_MAX_ROW_LENGTH;
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned SETTLE         = 8;
  localparam int          NUM_PHASES     = 11;
  localparam logic [swm_pkg::APB_ADDR_W-1:0] WIN_ADDR =
    swm_pkg::APB_ADDR_W'(4 * swm_pkg::REG_WINDOW_LENGTH);

  typedef enum int {
    PAT_RANDOM,
    PAT_CLUSTER,
    PAT_FALLING,
    PAT_RISING,
    PAT_EXTREME
  } sample_pattern_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]           pos;
    logic                       full;
  } max_result_t;

  class window_max_tracker;
    logic signed [SAMPLE_W-1:0] deque_value[$];
    int unsigned                deque_pos[$];
    int unsigned                row_pos;
    logic [6:0]                 window_reg;
    max_result_t                expected_max[$];
    int unsigned                results_seen;
    int unsigned                failures;

    function new();
      row_pos      = 0;
      window_reg   = swm_pkg::WINDOW_LENGTH_RST;
      results_seen = 0;
      failures     = 0;
    endfunction

    function void report_mismatch(string what);
      failures++;
      if (failures <= 10) $display("%s", what);
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] sample, logic row_start);
      int unsigned span;
      max_result_t r;
      span = (window_reg == 0) ? 1 : (window_reg > MAX_WIN) ? MAX_WIN : window_reg;
      if (row_start) begin
        deque_value.delete();
        deque_pos.delete();
        row_pos = 0;
      end
      if (row_pos < MAX_ROW) row_pos++;
      while (deque_pos.size() > 0 && deque_pos[0] + span <= row_pos) begin
        deque_value.delete(0);
        deque_pos.delete(0);
      end
      while (deque_value.size() > 0 && deque_value[$] <= sample) begin
        deque_value.delete(deque_value.size() - 1);
        deque_pos.delete(deque_pos.size() - 1);
      end
      if (deque_value.size() >= MAX_WIN) begin
        deque_value.delete(0);
        deque_pos.delete(0);
      end
      deque_value.insert(deque_value.size(), sample);
      deque_pos.insert(deque_pos.size(), row_pos);
      r.value = deque_value[0];
      r.pos   = POS_W'(deque_pos[0]);
      r.full  = (row_pos >= span);
      expected_max.insert(expected_max.size(), r);
    endfunction

    function void check_result(logic [31:0] tdata, logic tuser);
      max_result_t want;
      logic signed [SAMPLE_W-1:0] got_value;
      logic [POS_W-1:0] got_pos;
      got_value = tdata[SAMPLE_W-1:0];
      got_pos   = tdata[SAMPLE_W +: POS_W];
      results_seen++;
      if (expected_max.size() == 0) begin
        report_mismatch($sformatf("unexpected result: value %0d pos %0d full %0b",
                                  got_value, got_pos, tuser));
        return;
      end
      want = expected_max[0];
      expected_max.delete(0);
      if (got_value !== want.value || got_pos !== want.pos || tuser !== want.full)
        report_mismatch($sformatf(
          "result %0d: want value %0d pos %0d full %0b, got value %0d pos %0d full %0b",
          results_seen, want.value, want.pos, want.full, got_value, got_pos, tuser));
    endfunction
  endclass

  logic                          clk;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [15:0]                   s_tdata  = '0;   // sample_value
  logic                          s_tuser  = 1'b0; // row_start
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [31:0]                   m_tdata;         // max_value, max_position
  logic                          m_tuser;         // window_full
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [swm_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [swm_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [swm_pkg::APB_DATA_W-1:0] prdata;
  logic                          pready;

  window_max_tracker tracker;
  int unsigned       cycle_count      = 0;
  int unsigned       items_sent       = 0;
  int unsigned       settings_written = 0;
  logic              sender_steady    = 1'b0;
  logic              receiver_steady  = 1'b0;
  logic              receiver_holdoff = 1'b0;
  logic [6:0]        phase_window [NUM_PHASES] = '{2, 1, 5, 64, 65, 127, 0, 17, 3, 0, 64};

  sliding_window_maximum dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("tb_sliding_window_maximum: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) tracker.take_sample(s_tdata, s_tuser);
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
  end

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(9, 24);
  endfunction

  function automatic logic [15:0] next_sample(sample_pattern_t pat, logic signed [15:0] prev);
    int v;
    case (pat)
      PAT_CLUSTER: v = int'($urandom_range(0, 8)) - 4;
      PAT_FALLING: v = int'(prev) - int'($urandom_range(0, 40));
      PAT_RISING:  v = int'(prev) + int'($urandom_range(0, 40));
      PAT_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default:     v = int'($urandom);
    endcase
    return v[15:0];
  endfunction

  // receiver: random stalls, always ready in steady phases, or one long hold-off when asked
  initial begin
    int unsigned n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (receiver_holdoff) begin
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        receiver_holdoff = 1'b0;
      end else begin
        n = receiver_steady ? 0 : idle_span();
        m_tready <= (n == 0);
        repeat ((n == 0) ? 1 : n) @(posedge clk);
      end
    end
  end

  task automatic send_sample(input logic [15:0] value, input logic row_start);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= row_start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    gap = sender_steady ? 0 : idle_span();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results(input int unsigned settle);
    s_tvalid <= 1'b0;
    while (tracker.results_seen < items_sent) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic read_window(input logic [6:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WIN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[6:0] !== want)
      tracker.report_mismatch($sformatf("window_length read back %0d, want %0d",
                                        prdata[6:0], want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(input logic [6:0] len);
    wait_for_results(SETTLE);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIN_ADDR;
    pwdata  <= 32'(len);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tracker.window_reg = len;
    settings_written++;
    read_window(len);
  endtask

  task automatic run_rows(input int unsigned count, input logic [6:0] len);
    int unsigned done, row_len, k, span;
    sample_pattern_t pat;
    logic signed [15:0] level;
    logic opens_row;
    span  = (len == 0) ? 1 : (len > MAX_WIN) ? MAX_WIN : len;
    done  = 0;
    level = 16'($urandom);
    while (done < count) begin
      pat       = sample_pattern_t'($urandom_range(0, 4));
      row_len   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 2 * span + 4)
                                             : $urandom_range(1, 200);
      opens_row = ($urandom_range(0, 9) != 0);
      for (k = 0; k < row_len && done < count; k++) begin
        level = next_sample(pat, level);
        send_sample(level, (k == 0 && opens_row) || $urandom_range(0, 63) == 0);
        done++;
      end
    end
  endtask

  initial begin
    int unsigned p;
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_window(swm_pkg::WINDOW_LENGTH_RST);

    // window of one straight after reset, no row start, then directed rows at windows 3, 0 and 127
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    set_window(7'd3);
    send_sample(16'h7FFF, 1'b1);
    repeat (3) send_sample(16'h8000, 1'b0);
    repeat (3) send_sample(16'd5, 1'b0);
    send_sample(16'd4, 1'b0);
    send_sample(16'd3, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b0);
    set_window(7'd0);
    send_sample(16'd10, 1'b1);
    send_sample(16'd20, 1'b0);
    send_sample(16'd5, 1'b0);
    set_window(7'd127);
    send_sample(16'd100, 1'b1);
    send_sample(16'd99, 1'b0);
    send_sample(16'd98, 1'b0);
    send_sample(16'hFFFB, 1'b1);

    phase_window[8] = 7'($urandom_range(3, 63));
    phase_window[9] = 7'($urandom_range(0, 127));
    for (p = 0; p < NUM_PHASES; p++) begin
      set_window(phase_window[p]);
      sender_steady   = (p % 3 == 1);
      receiver_steady = (p % 4 == 2);
      if (p == 3) begin
        run_rows(40, phase_window[p]);
        receiver_holdoff = 1'b1;
        sender_steady    = 1'b1;
        run_rows(60, phase_window[p]);
      end else if (p == 5) begin
        run_rows(50, phase_window[p]);
        wait_for_results(1);
        run_rows(50, phase_window[p]);
      end else begin
        run_rows(100, phase_window[p]);
      end
    end

    wait_for_results(SETTLE);
    $display("summary: %0d samples in rows of mixed patterns, %0d results, %0d window settings",
             items_sent, tracker.results_seen, settings_written);
    $display("summary: %0d mismatches, %0d results outstanding",
             tracker.failures, tracker.expected_max.size());
    if (tracker.failures == 0 && tracker.expected_max.size() == 0) begin
      $display("tb_sliding_window_maximum: clean");
    end else begin
      $display("tb_sliding_window_maximum: errors");
    end
    $finish;
  end

endmodule
